### rtl/core/median_filter_3x3_edge_replicate_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 median filter
// Expect clk and arst_n in the scope of the use.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_EDGE_REPLICATE_ASSERT_SVH
`define MEDIAN_FILTER_3X3_EDGE_REPLICATE_ASSERT_SVH

// same-cycle implication
`define MF3X3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MF3X3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mf3x3_pkg.sv
// ----------------------------------------------------------------------------
// mf3x3_pkg
// Shared types and constants of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3x3_pkg;

	localparam int unsigned WIDTH_REG_BITS  = 11;
	localparam int unsigned HEIGHT_REG_BITS = 16;
	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd480;

	// register index = paddr[2]
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	localparam int unsigned WIN_TAPS   = 9;
	localparam int unsigned MED_CENTER = 4;
	localparam int unsigned MED_OPS    = 19;
	localparam int unsigned MED_SPLIT  = 9;   // ops done before the mid register

	typedef logic [3:0] tap_idx_t;

	// compare-exchange network for the median of nine: after an op, lo holds the min
	localparam tap_idx_t MED_OP_LO [MED_OPS] = '{
		4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7,
		4'd0, 4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
	};
	localparam tap_idx_t MED_OP_HI [MED_OPS] = '{
		4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8,
		4'd3, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
	};

	// which results one item releases, and how the window edges replicate
	typedef struct packed {
		logic prev_row;       // row above the incoming one is complete
		logic prev_top_rep;   // that row is the first: replicate it upward
		logic cur_row;        // incoming row is the last one
		logic cur_top_rep;    // single-row frame
		logic prev_col;       // column left of the incoming one is complete
		logic prev_left_rep;  // that column is the first
		logic cur_col;        // incoming column is the last one
		logic cur_left_rep;   // single-column frame
		logic frame_last;
	} job_ctrl_t;

	localparam int unsigned JOB_CTRL_BITS = $bits(job_ctrl_t);

	localparam int unsigned QUEUE_DEPTH = 4;
	typedef logic [2:0] queue_level_t;

endpackage

### rtl/core/mf3x3_ram.sv
// ----------------------------------------------------------------------------
// mf3x3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mf3x3_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/mf3x3_front.sv
// ----------------------------------------------------------------------------
// mf3x3_front
// Takes pixels, tracks position, keeps the line stores and window, and
// pushes one job (window plus release flags) per pixel into the queue.
// ----------------------------------------------------------------------------
module mf3x3_front
	import mf3x3_pkg::*;
#(
	parameter int unsigned PIXEL_BITS = 8,
	parameter int unsigned MAX_WIDTH  = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [WIDTH_REG_BITS-1:0]      image_width,
	input  logic [HEIGHT_REG_BITS-1:0]     image_height,
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  logic [PIXEL_BITS-1:0]          pixel_in,
	input  queue_level_t                   queue_level,
	output logic                           push,
	output job_ctrl_t                      push_ctrl,
	output logic [WIN_TAPS*PIXEL_BITS-1:0] push_win
);

	localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned MWB = $clog2(MAX_WIDTH + 1);
	localparam int unsigned WW  = (MWB > WIDTH_REG_BITS) ? MWB : WIDTH_REG_BITS;

	logic [CW-1:0]              col_q;
	logic [HEIGHT_REG_BITS-1:0] row_q;
	logic [WW-1:0]              w_ext, w_eff;
	logic [HEIGHT_REG_BITS-1:0] h_eff;
	logic                       last_col, last_row, accept;
	job_ctrl_t                  ctrl_now;

	logic                  v_s1, fwd_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [CW-1:0]         x_s1;
	job_ctrl_t             ctrl_s1;

	logic [PIXEL_BITS-1:0] up_rd, lo_rd, up_eff, lo_eff;
	logic [PIXEL_BITS-1:0] last_up_q, last_lo_q;
	logic [PIXEL_BITS-1:0] win_q    [WIN_TAPS];
	logic [PIXEL_BITS-1:0] win_next [WIN_TAPS];

	// ---- position and release classification ----
	always_comb begin
		w_ext = WW'(image_width);
		if (w_ext == '0) begin
			w_eff = WW'(1);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff    = (image_height == '0) ? HEIGHT_REG_BITS'(1) : image_height;
		last_col = WW'(col_q) >= (w_eff - WW'(1));
		last_row = row_q >= (h_eff - HEIGHT_REG_BITS'(1));

		ctrl_now.prev_row      = row_q != '0;
		ctrl_now.prev_top_rep  = row_q == HEIGHT_REG_BITS'(1);
		ctrl_now.cur_row       = last_row;
		ctrl_now.cur_top_rep   = row_q == '0;
		ctrl_now.prev_col      = col_q != '0;
		ctrl_now.prev_left_rep = col_q == CW'(1);
		ctrl_now.cur_col       = last_col;
		ctrl_now.cur_left_rep  = col_q == '0;
		ctrl_now.frame_last    = last_row & last_col;
	end

	// credit: every item in flight has a queue slot waiting
	assign pixel_ready = (4'(queue_level) + 4'(v_s1)) < 4'(QUEUE_DEPTH);
	assign accept      = pixel_valid & pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				// line store read of this item lands while the previous one writes
				fwd_s1 <= v_s1 && (x_s1 == col_q);
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + HEIGHT_REG_BITS'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel_in;
			x_s1    <= col_q;
			ctrl_s1 <= ctrl_now;
		end
	end

	// ---- line stores ----
	mf3x3_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_upper (
		.clk    (clk),
		.wr_en  (v_s1),
		.wr_addr(x_s1),
		.wr_data(lo_eff),
		.rd_addr(col_q),
		.rd_data(up_rd)
	);

	mf3x3_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_lower (
		.clk    (clk),
		.wr_en  (v_s1),
		.wr_addr(x_s1),
		.wr_data(px_s1),
		.rd_addr(col_q),
		.rd_data(lo_rd)
	);

	assign up_eff = fwd_s1 ? last_up_q : up_rd;
	assign lo_eff = fwd_s1 ? last_lo_q : lo_rd;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			last_up_q <= lo_eff;
			last_lo_q <= px_s1;
		end
	end

	// ---- window: tap = column*3 + row, column 2 is the newest ----
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r]     = win_q[3 + r];
			win_next[3 + r] = win_q[6 + r];
		end
		win_next[6] = up_eff;
		win_next[7] = lo_eff;
		win_next[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < WIN_TAPS; n++) begin
				win_q[n] <= '0;
			end
		end else if (v_s1) begin
			win_q <= win_next;
		end
	end

	always_comb begin
		for (int n = 0; n < WIN_TAPS; n++) begin
			push_win[n*PIXEL_BITS +: PIXEL_BITS] = win_next[n];
		end
	end

	assign push      = v_s1;
	assign push_ctrl = ctrl_s1;

endmodule

### rtl/core/mf3x3_fifo.sv
// ----------------------------------------------------------------------------
// mf3x3_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_edge_replicate_assert.svh"

module mf3x3_fifo
	import mf3x3_pkg::*;
#(
	parameter int unsigned WIDTH = 81
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data,
	output queue_level_t     level
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	queue_level_t     level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			level_q <= level_q + queue_level_t'(push) - queue_level_t'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = level_q != '0;
	assign head_data  = slot_q[rd_ptr_q];
	assign level      = level_q;

	`MF3X3_ASSERT_NOW(a_no_overflow, push, level_q != queue_level_t'(QUEUE_DEPTH), "job queue overflow")
	`MF3X3_ASSERT_NOW(a_no_underflow, pop, level_q != '0, "job queue underflow")
	`MF3X3_ASSERT_NOW(a_level_bound, 1'b1, level_q <= queue_level_t'(QUEUE_DEPTH), "job queue level out of range")

endmodule

### rtl/core/mf3x3_back.sv
// ----------------------------------------------------------------------------
// mf3x3_back
// Expands each job into its results, selects the replicated 3x3 taps and
// runs them through a two-stage median network into the output register.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_edge_replicate_assert.svh"

module mf3x3_back
	import mf3x3_pkg::*;
#(
	parameter int unsigned PIXEL_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  job_ctrl_t                      head_ctrl,
	input  logic [WIN_TAPS*PIXEL_BITS-1:0] head_win,
	output logic                           pop,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [PIXEL_BITS-1:0]          median_out,
	output logic                           frame_last
);

	logic adv, issue, empty_job, two_rows, two_cols, row_done, col_done;
	logic use_prev_row, use_prev_col, fl_issue;
	logic row_idx_q, col_idx_q;
	logic [1:0] rsel [3];
	logic [1:0] csel [3];
	logic [PIXEL_BITS-1:0] win   [WIN_TAPS];
	logic [PIXEL_BITS-1:0] taps  [WIN_TAPS];
	logic [PIXEL_BITS-1:0] net_a [WIN_TAPS];
	logic [PIXEL_BITS-1:0] net_b [WIN_TAPS];

	logic                  v_s1, v_s2, fl_s1, fl_s2;
	logic [PIXEL_BITS-1:0] pix_s1 [WIN_TAPS];
	logic [PIXEL_BITS-1:0] pix_s2 [WIN_TAPS];
	logic                  out_valid_q, frame_last_q;
	logic [PIXEL_BITS-1:0] median_q;

	// whole pipe moves when the output register can take a result
	assign adv = !out_valid_q || result_ready;

	// ---- result sequencer: rows outer, columns inner ----
	assign two_rows  = head_ctrl.prev_row & head_ctrl.cur_row;
	assign two_cols  = head_ctrl.prev_col & head_ctrl.cur_col;
	assign row_done  = !two_rows || row_idx_q;
	assign col_done  = !two_cols || col_idx_q;
	assign empty_job = !(head_ctrl.prev_row || head_ctrl.cur_row)
		|| !(head_ctrl.prev_col || head_ctrl.cur_col);

	assign issue    = adv && head_valid && !empty_job;
	assign pop      = adv && head_valid && (empty_job || (row_done && col_done));
	assign fl_issue = head_ctrl.frame_last && row_done && col_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_idx_q <= 1'b0;
			col_idx_q <= 1'b0;
		end else if (issue) begin
			if (col_done) begin
				col_idx_q <= 1'b0;
				row_idx_q <= !row_done;
			end else begin
				col_idx_q <= 1'b1;
			end
		end
	end

	// ---- tap selection with edge replication ----
	assign use_prev_row = head_ctrl.prev_row && !row_idx_q;
	assign use_prev_col = head_ctrl.prev_col && !col_idx_q;

	always_comb begin
		if (use_prev_row) begin
			rsel[0] = head_ctrl.prev_top_rep ? 2'd1 : 2'd0;
			rsel[1] = 2'd1;
		end else begin
			rsel[0] = head_ctrl.cur_top_rep ? 2'd2 : 2'd1;
			rsel[1] = 2'd2;
		end
		rsel[2] = 2'd2;
		if (use_prev_col) begin
			csel[0] = head_ctrl.prev_left_rep ? 2'd1 : 2'd0;
			csel[1] = 2'd1;
		end else begin
			csel[0] = head_ctrl.cur_left_rep ? 2'd2 : 2'd1;
			csel[1] = 2'd2;
		end
		csel[2] = 2'd2;

		for (int n = 0; n < WIN_TAPS; n++) begin
			win[n] = head_win[n*PIXEL_BITS +: PIXEL_BITS];
		end
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				taps[i*3 + k] = win[4'(csel[k]) * 4'd3 + 4'(rsel[i])];
			end
		end
	end

	// ---- median network, split over two registers ----
	always_comb begin
		logic [PIXEL_BITS-1:0] a, b;
		net_a = pix_s1;
		for (int k = 0; k < MED_SPLIT; k++) begin
			a = net_a[MED_OP_LO[k]];
			b = net_a[MED_OP_HI[k]];
			net_a[MED_OP_LO[k]] = (a < b) ? a : b;
			net_a[MED_OP_HI[k]] = (a < b) ? b : a;
		end
	end

	always_comb begin
		logic [PIXEL_BITS-1:0] a, b;
		net_b = pix_s2;
		for (int k = MED_SPLIT; k < MED_OPS; k++) begin
			a = net_b[MED_OP_LO[k]];
			b = net_b[MED_OP_HI[k]];
			net_b[MED_OP_LO[k]] = (a < b) ? a : b;
			net_b[MED_OP_HI[k]] = (a < b) ? b : a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1       <= taps;
			fl_s1        <= fl_issue;
			pix_s2       <= net_a;
			fl_s2        <= fl_s1;
			median_q     <= net_b[MED_CENTER];
			frame_last_q <= fl_s2;
		end
	end

	assign result_valid = out_valid_q;
	assign median_out   = median_q;
	assign frame_last   = frame_last_q;

	`MF3X3_ASSERT_NOW(a_row_idx_job, row_idx_q, head_valid && two_rows, "second row step without a two-row job")
	`MF3X3_ASSERT_NOW(a_col_idx_job, col_idx_q, head_valid && two_cols, "second column step without a two-column job")
	`MF3X3_ASSERT_NEXT(a_idx_clear_on_pop, pop && !empty_job, !row_idx_q && !col_idx_q, "sequencer not rewound after job")

endmodule

### rtl/core/median_filter_3x3_edge_replicate.sv
// Throughput: one item per cycle while the job queue has credit; the back end gives one
// result per cycle while result_ready is high, so an item that releases several results
// (up to four at the last row and column) holds the back end until all of them have issued.
// A 4-entry job queue with credit-based ready decouples pixel intake from result output.
// Reset (arst_n, async, active low): counters, window, queue and pipe clear; registers
// return to 640 x 480. Line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// median_filter_3x3_edge_replicate
// 3x3 median over a raster pixel stream with replicated image edges.
// ----------------------------------------------------------------------------
module median_filter_3x3_edge_replicate
	import mf3x3_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  logic [PIXEL_BITS-1:0] pixel_in,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [PIXEL_BITS-1:0] median_out,
	output logic                  frame_last
);

	localparam int unsigned JOB_BITS = JOB_CTRL_BITS + WIN_TAPS * PIXEL_BITS;

	logic [WIDTH_REG_BITS-1:0]      width_q;
	logic [HEIGHT_REG_BITS-1:0]     height_q;
	reg_idx_t                       reg_sel;
	logic                           push, pop, head_valid;
	job_ctrl_t                      push_ctrl, head_ctrl;
	logic [WIN_TAPS*PIXEL_BITS-1:0] push_win, head_win;
	logic [JOB_BITS-1:0]            head_data;
	queue_level_t                   level;

	// ---- configuration port ----
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_IMAGE_WIDTH: begin
					width_q <= pwdata[WIDTH_REG_BITS-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= pwdata[HEIGHT_REG_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	// ---- datapath ----
	mf3x3_front #(
		.PIXEL_BITS(PIXEL_BITS),
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (width_q),
		.image_height(height_q),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_in    (pixel_in),
		.queue_level (level),
		.push        (push),
		.push_ctrl   (push_ctrl),
		.push_win    (push_win)
	);

	mf3x3_fifo #(
		.WIDTH(JOB_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ctrl, push_win}),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data),
		.level     (level)
	);

	assign head_ctrl = job_ctrl_t'(head_data[JOB_BITS-1 -: JOB_CTRL_BITS]);
	assign head_win  = head_data[WIN_TAPS*PIXEL_BITS-1:0];

	mf3x3_back #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_ctrl   (head_ctrl),
		.head_win    (head_win),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.median_out  (median_out),
		.frame_last  (frame_last)
	);

endmodule
